### hw/rtl/dift_pkg.sv
// Shared types and constants for the in-flight frame tracker.
// No dependencies; used by decoder_inflight_frame_tracker_top.
`default_nettype none

package dift_pkg;

  localparam int TableDepthDefault = 24;

  // Actions carried by an input item.
  localparam logic [2:0] ACT_TRACK    = 3'd0;
  localparam logic [2:0] ACT_EOS      = 3'd1;
  localparam logic [2:0] ACT_DECODED  = 3'd2;
  localparam logic [2:0] ACT_RELEASED = 3'd3;
  localparam logic [2:0] ACT_QUERY    = 3'd4;
  localparam logic [2:0] ACT_SRESET   = 3'd5;

  // Entry status codes.
  localparam logic [1:0] ST_DECODING = 2'd0;
  localparam logic [1:0] ST_DECODED  = 2'd1;
  localparam logic [1:0] ST_RELEASED = 2'd2;

  // Kill causes.
  localparam logic [1:0] KILL_NONE  = 2'd0;
  localparam logic [1:0] KILL_FULL  = 2'd1;
  localparam logic [1:0] KILL_COUNT = 2'd2;
  localparam logic [1:0] KILL_DUP   = 2'd3;

  // Configuration register indexes.
  localparam logic [1:0] REG_INIT_LIMIT  = 2'd0;
  localparam logic [1:0] REG_LOW_WM      = 2'd1;
  localparam logic [1:0] REG_FIRST_LIMIT = 2'd2;

  localparam logic [7:0] INIT_LIMIT_RST  = 8'd8;
  localparam logic [4:0] LOW_WM_RST      = 5'd2;
  localparam logic [4:0] FIRST_LIMIT_RST = 5'd10;
  localparam logic [4:0] PENDING_MAX     = 5'd31;
  localparam logic [7:0] LIMIT_MAX       = 8'd255;

  typedef struct packed {
    logic [2:0]         action;
    logic signed [63:0] frame_time;
    logic signed [63:0] release_time;
    logic signed [63:0] now_time;
  } in_item_t;

  typedef struct packed {
    logic       accept_more;
    logic       is_disabled;
    logic [1:0] kill_cause;
    logic [4:0] decoding_count;
    logic [4:0] decoded_count;
    logic [7:0] frame_limit_now;
  } out_item_t;

  typedef struct packed {
    logic [63:0] ftime;
    logic [63:0] rtime;
    logic [1:0]  status;
  } entry_t;

endpackage

`default_nettype wire

### hw/rtl/decoder_inflight_frame_tracker_top.sv
// Top level of the in-flight frame tracker: control sequencer and entry table memory.
// Depends on dift_pkg for item types, action codes and reset values.
//
// Usage: raise start with an item on in_data while busy is low; the item is taken at
// that edge and busy stays high until its result. The result appears on out_data for
// exactly one cycle with out_valid high, one result per item; the receiver cannot
// stall, so it must take it in that cycle. The next item is taken the cycle after.
// Configuration writes use cfg_valid/cfg_ready with cfg_index and cfg_data; the user
// must issue them only while the block is idle, as the block itself does not enforce
// it. A write to the initial limit also loads the live frame limit.
// The table lives in one synchronous memory with one read and one write port, and
// every walk visits one entry per cycle. A query prunes released entries, a mark walks
// the table and then prunes, and a track prunes and then walks down to make room;
// other actions go straight to the result.
// Reset clears the counters, flags and kill switch and loads the register defaults;
// the table memory needs no clearing since entries at or past the count are never read.
`default_nettype none

module decoder_inflight_frame_tracker_top #(
  parameter int TABLE_DEPTH = dift_pkg::TableDepthDefault
) (
  input  wire                      clk,
  input  wire                      rst_n,
  input  wire                      start,
  output logic                     busy,
  input  wire dift_pkg::in_item_t  in_data,
  output logic                     out_valid,
  output dift_pkg::out_item_t      out_data,
  input  wire                      cfg_valid,
  output logic                     cfg_ready,
  input  wire  [1:0]               cfg_index,
  input  wire  [7:0]               cfg_data
);

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int XW = 9;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_PRUNE  = 3'd1;
  localparam logic [2:0] S_MARK   = 3'd2;
  localparam logic [2:0] S_TRK    = 3'd3;
  localparam logic [2:0] S_PLACE  = 3'd4;
  localparam logic [2:0] S_REPORT = 3'd5;

  logic [2:0]         state_r, state_nxt, ret_r, ret_nxt;
  logic [2:0]         act_r, act_nxt;
  logic signed [63:0] key_r, key_nxt, rel_r, rel_nxt, now_r, now_nxt;
  logic [CW-1:0]      cnt_r, cnt_nxt, done_r, done_nxt;
  logic [CW-1:0]      idx_r, idx_nxt, pidx_r, pidx_nxt, w_r, w_nxt, pos_r, pos_nxt;
  logic [4:0]         pend_r, pend_nxt, lowwm_r, lowwm_nxt, ffl_r, ffl_nxt;
  logic [7:0]         flim_r, flim_nxt;
  logic               limr_r, limr_nxt, ended_r, ended_nxt, killed_r, killed_nxt;
  logic [1:0]         kcode_r, kcode_nxt;
  logic               pv_r, pv_nxt, stop_r, stop_nxt, init_r, init_nxt, more_r, more_nxt;

  dift_pkg::entry_t   mem [TABLE_DEPTH];
  dift_pkg::entry_t   rdata_r, e, wd;
  logic               rd_en, we, issue, halt_now;
  logic [AW-1:0]      rd_addr, wa;
  logic [7:0]         bound;
  logic [CW:0]        remain;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    if (rd_en) begin
      rdata_r <= mem[rd_addr];
    end
  end

  assign busy      = (state_r != S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = (state_r == S_REPORT);
  assign e         = rdata_r;
  assign bound     = (flim_r > 8'(ffl_r)) ? flim_r : 8'(ffl_r);
  // Entries left after removing the one at pidx: kept so far plus those not yet visited.
  assign remain    = (CW+1)'(w_r) + (CW+1)'(cnt_r) - (CW+1)'(pidx_r) - (CW+1)'(1);

  always_comb begin
    out_data.accept_more     = killed_r ? 1'b1 :
                               (done_r == '0) ? (XW'(cnt_r) < XW'(ffl_r))
                                              : (XW'(cnt_r) < XW'(flim_r));
    out_data.is_disabled     = killed_r;
    out_data.kill_cause      = kcode_r;
    out_data.decoding_count  = 5'(cnt_r - done_r);
    out_data.decoded_count   = 5'(done_r);
    out_data.frame_limit_now = flim_r;
  end

  always_comb begin
    state_nxt = state_r; ret_nxt = ret_r; act_nxt = act_r;
    key_nxt = key_r; rel_nxt = rel_r; now_nxt = now_r;
    cnt_nxt = cnt_r; done_nxt = done_r; idx_nxt = idx_r; pidx_nxt = pidx_r;
    w_nxt = w_r; pos_nxt = pos_r; pend_nxt = pend_r; lowwm_nxt = lowwm_r;
    ffl_nxt = ffl_r; flim_nxt = flim_r; limr_nxt = limr_r; ended_nxt = ended_r;
    killed_nxt = killed_r; kcode_nxt = kcode_r;
    pv_nxt = pv_r; stop_nxt = stop_r; init_nxt = init_r; more_nxt = more_r;
    rd_en = 1'b0; rd_addr = idx_r[AW-1:0];
    we = 1'b0; wa = '0; wd = rdata_r;
    issue = 1'b0; halt_now = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (start) begin
          act_nxt = in_data.action;
          key_nxt = in_data.frame_time;
          rel_nxt = in_data.release_time;
          now_nxt = in_data.now_time;
          idx_nxt = '0; w_nxt = '0; pv_nxt = 1'b0; stop_nxt = 1'b0; init_nxt = 1'b1;
          state_nxt = S_REPORT;
          case (in_data.action)
            dift_pkg::ACT_TRACK: begin
              if (!killed_r && !ended_r) begin
                state_nxt = S_PRUNE; ret_nxt = S_TRK;
              end
            end
            dift_pkg::ACT_EOS: begin
              if (!killed_r) ended_nxt = 1'b1;
            end
            dift_pkg::ACT_DECODED, dift_pkg::ACT_RELEASED: begin
              if (!killed_r) state_nxt = S_MARK;
            end
            dift_pkg::ACT_QUERY: begin
              if (!killed_r) begin
                state_nxt = S_PRUNE; ret_nxt = S_REPORT;
              end
            end
            dift_pkg::ACT_SRESET: begin
              cnt_nxt = '0; done_nxt = '0; pend_nxt = '0;
              ended_nxt = 1'b0; limr_nxt = 1'b0;
            end
            default: ;
          endcase
        end
      end

      S_MARK: begin
        if (pv_r && !stop_r) begin
          if ($signed(e.ftime) <= key_r) begin
            wd = e;
            wa = pidx_r[AW-1:0];
            if (act_r == dift_pkg::ACT_DECODED) begin
              we = 1'b1;
              wd.status = dift_pkg::ST_DECODED;
              if (e.status == dift_pkg::ST_DECODING) done_nxt = done_r + CW'(1);
            end else if (e.status != dift_pkg::ST_RELEASED) begin
              we = 1'b1;
              wd.status = dift_pkg::ST_RELEASED;
              wd.rtime  = rel_r;
              if (e.status == dift_pkg::ST_DECODING) done_nxt = done_r + CW'(1);
              if (pend_r < dift_pkg::PENDING_MAX) pend_nxt = pend_r + 5'd1;
            end
          end else begin
            halt_now = 1'b1;
            stop_nxt = 1'b1;
          end
        end
        issue = !stop_r && !halt_now && (idx_r < cnt_r);
        if (issue) begin
          rd_en = 1'b1; pidx_nxt = idx_r; idx_nxt = idx_r + CW'(1);
        end
        pv_nxt = issue;
        if (!pv_r && !issue) begin
          state_nxt = S_PRUNE; ret_nxt = S_REPORT;
          idx_nxt = '0; w_nxt = '0; init_nxt = 1'b1; stop_nxt = 1'b0;
        end
      end

      S_PRUNE: begin
        if (init_r && pend_r == '0) begin
          state_nxt = ret_r;
        end else begin
          init_nxt = 1'b0;
          if (pv_r) begin
            if (e.status == dift_pkg::ST_RELEASED && $signed(now_r) >= $signed(e.rtime)) begin
              if (pend_r != '0) pend_nxt = pend_r - 5'd1;
              done_nxt = done_r - CW'(1);
              if (limr_r && remain <= (CW+1)'(lowwm_r)) begin
                if (flim_r < dift_pkg::LIMIT_MAX) flim_nxt = flim_r + 8'd1;
                limr_nxt = 1'b0;
              end
            end else begin
              we = 1'b1; wa = w_r[AW-1:0]; wd = e;
              w_nxt = w_r + CW'(1);
            end
          end
          issue = (idx_r < cnt_r);
          if (issue) begin
            rd_en = 1'b1; pidx_nxt = idx_r; idx_nxt = idx_r + CW'(1);
          end
          pv_nxt = issue;
          if (!pv_r && !issue) begin
            cnt_nxt = w_r;
            state_nxt = ret_r;
            init_nxt = 1'b1;
          end
        end
      end

      S_TRK: begin
        if (init_r) begin
          init_nxt = 1'b0; pv_nxt = 1'b0; stop_nxt = 1'b0; pos_nxt = '0;
          idx_nxt = cnt_r - CW'(1);
          more_nxt = 1'b1;
          if (XW'(cnt_r) >= XW'(TABLE_DEPTH)) begin
            killed_nxt = 1'b1; kcode_nxt = dift_pkg::KILL_FULL;
            cnt_nxt = '0; done_nxt = '0; state_nxt = S_REPORT;
          end else if (XW'(cnt_r) > XW'(bound)) begin
            killed_nxt = 1'b1; kcode_nxt = dift_pkg::KILL_COUNT;
            cnt_nxt = '0; done_nxt = '0; state_nxt = S_REPORT;
          end else if (cnt_r == '0) begin
            state_nxt = S_PLACE;
          end
        end else begin
          // Walk down from the top, shifting later entries up by one slot.
          if (pv_r && !stop_r) begin
            if (e.ftime == key_r) begin
              halt_now = 1'b1;
              killed_nxt = 1'b1; kcode_nxt = dift_pkg::KILL_DUP;
              cnt_nxt = '0; done_nxt = '0; state_nxt = S_REPORT;
            end else if ($signed(e.ftime) > key_r) begin
              we = 1'b1; wd = e;
              wa = AW'(pidx_r + CW'(1));
              pos_nxt = pidx_r;
            end else begin
              halt_now = 1'b1; stop_nxt = 1'b1;
              pos_nxt = pidx_r + CW'(1);
            end
          end
          issue = more_r && !stop_r && !halt_now;
          if (issue) begin
            rd_en = 1'b1; pidx_nxt = idx_r;
            more_nxt = (idx_r != '0);
            idx_nxt = idx_r - CW'(1);
          end
          pv_nxt = issue;
          if (!pv_r && !issue && !halt_now) state_nxt = S_PLACE;
        end
      end

      S_PLACE: begin
        we = 1'b1;
        wa = pos_r[AW-1:0];
        wd.ftime = key_r;
        wd.rtime = '0;
        wd.status = dift_pkg::ST_DECODING;
        cnt_nxt = cnt_r + CW'(1);
        if (XW'(cnt_r) + XW'(1) >= XW'(flim_r)) limr_nxt = 1'b1;
        state_nxt = S_REPORT;
      end

      S_REPORT: state_nxt = S_IDLE;

      default: state_nxt = S_IDLE;
    endcase

    if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        dift_pkg::REG_INIT_LIMIT:  flim_nxt = (cfg_data == '0) ? 8'd1 : cfg_data;
        dift_pkg::REG_LOW_WM:      lowwm_nxt = cfg_data[4:0];
        dift_pkg::REG_FIRST_LIMIT: ffl_nxt = cfg_data[4:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE; ret_r <= S_REPORT;
      cnt_r <= '0; done_r <= '0; pend_r <= '0;
      flim_r <= dift_pkg::INIT_LIMIT_RST;
      lowwm_r <= dift_pkg::LOW_WM_RST;
      ffl_r <= dift_pkg::FIRST_LIMIT_RST;
      limr_r <= 1'b0; ended_r <= 1'b0; killed_r <= 1'b0;
      kcode_r <= dift_pkg::KILL_NONE;
      pv_r <= 1'b0; stop_r <= 1'b0; init_r <= 1'b0; more_r <= 1'b0;
    end else begin
      state_r <= state_nxt; ret_r <= ret_nxt;
      cnt_r <= cnt_nxt; done_r <= done_nxt; pend_r <= pend_nxt;
      flim_r <= flim_nxt; lowwm_r <= lowwm_nxt; ffl_r <= ffl_nxt;
      limr_r <= limr_nxt; ended_r <= ended_nxt; killed_r <= killed_nxt;
      kcode_r <= kcode_nxt;
      pv_r <= pv_nxt; stop_r <= stop_nxt; init_r <= init_nxt; more_r <= more_nxt;
    end
  end

  always_ff @(posedge clk) begin
    act_r <= act_nxt; key_r <= key_nxt; rel_r <= rel_nxt; now_r <= now_nxt;
    idx_r <= idx_nxt; pidx_r <= pidx_nxt; w_r <= w_nxt; pos_r <= pos_nxt;
  end

  a_done_le_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    done_r <= cnt_r) else $error("decoded count exceeds table size");

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    XW'(cnt_r) <= XW'(TABLE_DEPTH)) else $error("table size beyond depth");

  a_killed_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && killed_r) |-> (cnt_r == '0 && kcode_r != dift_pkg::KILL_NONE))
    else $error("disabled tracker reports a non-empty table");

  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy) else $error("accepted item did not raise busy");

endmodule

`default_nettype wire

### test/testbench.sv
// Self-checking testbench for decoder_inflight_frame_tracker_top: a queue-fed driver,
// a result monitor and an item-level predictor of the frame table. Depends on dift_pkg.
// The run goes through several register settings and ends with one kill of the tracker.
`default_nettype none

module testbench;

  localparam int Depth = dift_pkg::TableDepthDefault;
  localparam int CycleLimit = 1000000;
  localparam int RandItems = 1800;
  localparam logic [2:0] ACT_UNUSED6 = 3'd6;
  localparam logic [2:0] ACT_UNUSED7 = 3'd7;

  typedef struct {
    dift_pkg::in_item_t item;
    int                 gap;
    bit                 drain;
  } pending_t;

  logic                 clk;
  logic                 rst_n;
  logic                 start;
  logic                 busy;
  dift_pkg::in_item_t   in_data;
  logic                 out_valid;
  dift_pkg::out_item_t  out_data;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [1:0]           cfg_index;
  logic [7:0]           cfg_data;

  decoder_inflight_frame_tracker_top dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_data(in_data),
    .out_valid(out_valid), .out_data(out_data), .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  pending_t             item_q[$];
  dift_pkg::out_item_t  status_q[$];
  int          errors = 0;
  int          accepted = 0;
  int          results = 0;
  int          cycles = 0;
  int          wait_cnt = 0;
  int          phases = 0;
  bit          burst = 0;

  // Predictor state of the frame table.
  logic signed [63:0] p_time[Depth];
  logic signed [63:0] p_rel[Depth];
  logic [1:0]         p_status[Depth];
  int                 p_count;
  int                 p_pending;
  int                 p_limit;
  bit                 p_reached;
  bit                 p_ended;
  bit                 p_killed;
  logic [1:0]         p_cause;
  int                 c_low_wm;
  int                 c_first;

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles", cycles);
      $display("DONE: errors detected");
      $finish;
    end
  end

  function automatic void prune_released(logic signed [63:0] now);
    int w;
    w = 0;
    if (p_pending == 0) return;
    for (int r = 0; r < p_count; r++) begin
      if (p_status[r] == dift_pkg::ST_RELEASED && now >= p_rel[r]) begin
        if (p_pending > 0) p_pending--;
        if (p_reached && (w + (p_count - r - 1)) <= c_low_wm) begin
          if (p_limit < 255) p_limit++;
          p_reached = 0;
        end
      end else begin
        p_time[w] = p_time[r];
        p_status[w] = p_status[r];
        p_rel[w] = p_rel[r];
        w++;
      end
    end
    p_count = w;
  endfunction

  function automatic void kill_tracker(logic [1:0] cause);
    p_killed = 1;
    p_cause = cause;
    p_count = 0;
  endfunction

  function automatic void track_frame(logic signed [63:0] key, logic signed [63:0] now);
    int pos;
    int bound;
    pos = 0;
    if (p_killed || p_ended) return;
    prune_released(now);
    while (pos < p_count && p_time[pos] < key) pos++;
    bound = (p_limit > c_first) ? p_limit : c_first;
    if (p_count >= Depth) begin
      kill_tracker(dift_pkg::KILL_FULL);
    end else if (p_count > bound) begin
      kill_tracker(dift_pkg::KILL_COUNT);
    end else if (pos < p_count && p_time[pos] == key) begin
      kill_tracker(dift_pkg::KILL_DUP);
    end else begin
      for (int i = p_count; i > pos; i--) begin
        p_time[i] = p_time[i-1];
        p_status[i] = p_status[i-1];
        p_rel[i] = p_rel[i-1];
      end
      p_time[pos] = key;
      p_status[pos] = dift_pkg::ST_DECODING;
      p_rel[pos] = '0;
      p_count++;
      if (p_count >= p_limit) p_reached = 1;
    end
  endfunction

  function automatic void mark_frames(logic signed [63:0] key, bit rel_mark,
                                      logic signed [63:0] rel, logic signed [63:0] now);
    if (p_killed) return;
    for (int i = 0; i < p_count && p_time[i] <= key; i++) begin
      if (!rel_mark) begin
        p_status[i] = dift_pkg::ST_DECODED;
      end else if (p_status[i] != dift_pkg::ST_RELEASED) begin
        p_status[i] = dift_pkg::ST_RELEASED;
        p_rel[i] = rel;
        if (p_pending < 31) p_pending++;
      end
    end
    prune_released(now);
  endfunction

  function automatic dift_pkg::out_item_t tracker_status(dift_pkg::in_item_t it);
    dift_pkg::out_item_t o;
    int dec;
    int done;
    dec = 0;
    done = 0;
    case (it.action)
      dift_pkg::ACT_TRACK:    track_frame(it.frame_time, it.now_time);
      dift_pkg::ACT_EOS:      if (!p_killed) p_ended = 1;
      dift_pkg::ACT_DECODED:  mark_frames(it.frame_time, 0, '0, it.now_time);
      dift_pkg::ACT_RELEASED: mark_frames(it.frame_time, 1, it.release_time, it.now_time);
      dift_pkg::ACT_QUERY:    if (!p_killed) prune_released(it.now_time);
      dift_pkg::ACT_SRESET: begin
        p_count = 0;
        p_pending = 0;
        p_ended = 0;
        p_reached = 0;
      end
      default: ;
    endcase
    for (int i = 0; i < p_count; i++) begin
      if (p_status[i] == dift_pkg::ST_DECODING) dec++;
      else done++;
    end
    if (p_killed) o.accept_more = 1;
    else if (done == 0) o.accept_more = (dec + done) < c_first;
    else o.accept_more = (dec + done) < p_limit;
    o.is_disabled = p_killed;
    o.kill_cause = p_cause;
    o.decoding_count = dec[4:0];
    o.decoded_count = done[4:0];
    o.frame_limit_now = p_limit[7:0];
    return o;
  endfunction

  // Driver: launches the next item after its drawn gap; an item marked drain waits
  // until every outstanding result has come back.
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 0;
      in_data <= '0;
      wait_cnt = 0;
    end else if (start && !busy) begin
      status_q.push_back(tracker_status(in_data));
      accepted++;
      start <= 0;
    end else if (!start && item_q.size() > 0) begin
      if (wait_cnt < item_q[0].gap || (item_q[0].drain && status_q.size() > 0)) begin
        wait_cnt++;
      end else begin
        in_data <= item_q[0].item;
        start <= 1;
        item_q.pop_front();
        wait_cnt = 0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      results++;
      if (status_q.size() == 0) begin
        $display("%0t: unexpected result %p", $realtime, out_data);
        errors++;
      end else begin
        if (out_data !== status_q[0]) begin
          $display("%0t: mismatch expected %p actual %p", $realtime, status_q[0], out_data);
          errors++;
        end
        status_q.pop_front();
      end
    end
  end

  function automatic logic signed [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  task automatic push_item(logic [2:0] act, logic signed [63:0] ft, logic signed [63:0] rt,
                           logic signed [63:0] nt);
    pending_t p;
    p.item.action = act;
    p.item.frame_time = ft;
    p.item.release_time = rt;
    p.item.now_time = nt;
    p.gap = (burst || $urandom_range(3) == 0) ? 0 : $urandom_range(16);
    p.drain = ($urandom_range(199) == 0);
    item_q.push_back(p);
  endtask

  task automatic wait_idle();
    do @(negedge clk);
    while (item_q.size() > 0 || start || busy || status_q.size() > 0);
    repeat (80) @(negedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [7:0] val);
    @(posedge clk);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 0;
    case (idx)
      dift_pkg::REG_INIT_LIMIT:  p_limit = (val != 0) ? val : 1;
      dift_pkg::REG_LOW_WM:      c_low_wm = val & 8'h1f;
      dift_pkg::REG_FIRST_LIMIT: c_first = val & 8'h1f;
      default: ;
    endcase
  endtask

  task automatic set_config(logic [7:0] init, logic [7:0] wm, logic [7:0] first);
    wait_idle();
    write_reg(dift_pkg::REG_INIT_LIMIT, init);
    write_reg(dift_pkg::REG_LOW_WM, wm);
    write_reg(dift_pkg::REG_FIRST_LIMIT, first);
    phases++;
  endtask

  // One well-formed episode: tracks in shuffled order, decode and release marks, pruning
  // queries with time moving forward, a little noise, and a soft reset at the end.
  task automatic gen_episode(ref int made);
    logic signed [63:0] ts[Depth];
    logic signed [63:0] tmp;
    logic signed [63:0] base;
    logic signed [63:0] now;
    int bound;
    int k;
    int j;
    int stepv;
    bit eos;
    bound = (p_limit > c_first) ? p_limit : c_first;
    k = (bound + 1 < Depth) ? bound + 1 : Depth;
    k = ($urandom_range(2) == 0) ? ((p_limit < k) ? p_limit : k) : $urandom_range(1, k);
    base = ($urandom_range(3) == 0) ? rand64() : $signed(64'($urandom_range(100000)));
    now = ($urandom_range(3) == 0) ? rand64() : $signed(64'($urandom_range(100000)));
    stepv = $urandom_range(1, 1000);
    eos = ($urandom_range(9) == 0);
    burst = ($urandom_range(3) == 0);
    for (int i = 0; i < k; i++) ts[i] = base + i * stepv;
    for (int i = k - 1; i > 0; i--) begin
      j = $urandom_range(i);
      tmp = ts[i];
      ts[i] = ts[j];
      ts[j] = tmp;
    end
    for (int i = 0; i < k; i++) begin
      if (eos && i == k / 2) push_item(dift_pkg::ACT_EOS, rand64(), rand64(), now);
      push_item(dift_pkg::ACT_TRACK, ts[i], rand64(), now);
      now += $urandom_range(50);
      if ($urandom_range(3) == 0)
        push_item(dift_pkg::ACT_DECODED, ts[$urandom_range(i)], rand64(), now);
      if ($urandom_range(5) == 0) push_item(dift_pkg::ACT_QUERY, rand64(), rand64(), now);
      if ($urandom_range(9) == 0)
        push_item(3'(ACT_UNUSED6 + $urandom_range(1)), rand64(), rand64(), rand64());
    end
    for (int i = 0; i < $urandom_range(1, 6); i++) begin
      case ($urandom_range(3))
        0: push_item(dift_pkg::ACT_DECODED, base + $urandom_range(k - 1) * stepv, rand64(),
                     now);
        1: push_item(dift_pkg::ACT_RELEASED, base + $urandom_range(k - 1) * stepv,
                     now + $signed(64'($urandom_range(300))) - 100, now);
        2: push_item(dift_pkg::ACT_QUERY, rand64(), rand64(), now);
        default: push_item(dift_pkg::ACT_RELEASED, rand64(), rand64(), rand64());
      endcase
      now += $urandom_range(100);
    end
    push_item(dift_pkg::ACT_DECODED, base + (k - 1) * stepv, rand64(), now);
    push_item(dift_pkg::ACT_RELEASED, base + (k - 1) * stepv, now, now);
    push_item(dift_pkg::ACT_QUERY, rand64(), rand64(), now + 1000);
    push_item(dift_pkg::ACT_SRESET, rand64(), rand64(), rand64());
    made += item_q.size();
  endtask

  task automatic run_random(int n);
    int made;
    made = 0;
    while (made < n) begin
      made -= item_q.size();
      gen_episode(made);
    end
  endtask

  initial begin
    logic signed [63:0] lo;
    logic signed [63:0] hi;
    int cause;
    lo = 64'sh8000000000000000;
    hi = 64'sh7fffffffffffffff;
    rst_n = 0;
    cfg_valid = 0;
    cfg_index = dift_pkg::REG_INIT_LIMIT;
    cfg_data = '0;
    p_count = 0;
    p_pending = 0;
    p_limit = dift_pkg::INIT_LIMIT_RST;
    p_reached = 0;
    p_ended = 0;
    p_killed = 0;
    p_cause = dift_pkg::KILL_NONE;
    c_low_wm = dift_pkg::LOW_WM_RST;
    c_first = dift_pkg::FIRST_LIMIT_RST;
    repeat (11) @(posedge clk);
    rst_n <= 1;

    // Directed part under reset defaults: timestamp extremes, every action, unused codes,
    // tracks after end of stream, and releases pruned by a later query.
    push_item(dift_pkg::ACT_QUERY, lo, lo, lo);
    push_item(dift_pkg::ACT_TRACK, lo, hi, lo);
    push_item(dift_pkg::ACT_TRACK, hi, lo, lo);
    push_item(dift_pkg::ACT_TRACK, 64'sd0, 64'sd0, 64'sd0);
    push_item(dift_pkg::ACT_TRACK, -64'sd1, -64'sd1, -64'sd1);
    push_item(dift_pkg::ACT_DECODED, lo, hi, lo);
    push_item(dift_pkg::ACT_DECODED, 64'sd0, lo, lo);
    push_item(dift_pkg::ACT_RELEASED, -64'sd1, hi, lo);
    push_item(dift_pkg::ACT_QUERY, hi, hi, 64'sd0);
    push_item(dift_pkg::ACT_QUERY, lo, lo, hi);
    push_item(dift_pkg::ACT_DECODED, hi, hi, lo);
    push_item(dift_pkg::ACT_RELEASED, hi, lo, lo);
    push_item(dift_pkg::ACT_DECODED, hi, 64'sd0, lo);
    push_item(dift_pkg::ACT_RELEASED, hi, lo, hi);
    push_item(ACT_UNUSED6, hi, hi, hi);
    push_item(ACT_UNUSED7, lo, lo, lo);
    push_item(dift_pkg::ACT_EOS, hi, hi, hi);
    push_item(dift_pkg::ACT_TRACK, 64'sd5, 64'sd0, 64'sd0);
    push_item(dift_pkg::ACT_QUERY, 64'sd0, 64'sd0, hi);
    push_item(dift_pkg::ACT_SRESET, hi, hi, hi);
    push_item(dift_pkg::ACT_TRACK, 64'sd7, 64'sd0, 64'sd0);
    push_item(dift_pkg::ACT_SRESET, lo, lo, lo);
    item_q[5].drain = 1;
    run_random(RandItems / 6);

    set_config(8'd1, 8'd0, 8'd1);
    run_random(RandItems / 6);
    set_config(8'd255, 8'd24, 8'd24);
    run_random(RandItems / 6);
    set_config(8'd0, 8'd5, 8'd3);
    run_random(RandItems / 6);
    set_config(8'd4, 8'd3, 8'd6);
    run_random(RandItems / 6);
    set_config(8'($urandom_range(1, 24)), 8'($urandom_range(24)), 8'($urandom_range(1, 24)));
    run_random(RandItems / 6);

    // The kill switch cannot be cleared without a hard reset, so it comes last.
    cause = $urandom_range(1, 3);
    if (cause == dift_pkg::KILL_FULL) begin
      set_config(8'd255, 8'd2, 8'd24);
      for (int i = 0; i < Depth + 1; i++)
        push_item(dift_pkg::ACT_TRACK, 64'(i * 3), 64'sd0, 64'sd0);
    end else if (cause == dift_pkg::KILL_COUNT) begin
      set_config(8'd1, 8'd0, 8'd1);
      for (int i = 0; i < 3; i++) push_item(dift_pkg::ACT_TRACK, 64'(i), 64'sd0, 64'sd0);
    end else begin
      set_config(8'd8, 8'd2, 8'd10);
      push_item(dift_pkg::ACT_TRACK, lo, 64'sd0, 64'sd0);
      push_item(dift_pkg::ACT_TRACK, lo, 64'sd0, 64'sd0);
    end
    for (int i = 0; i < 16; i++) push_item(3'($urandom_range(7)), rand64(), rand64(), rand64());
    push_item(dift_pkg::ACT_SRESET, 64'sd0, 64'sd0, 64'sd0);
    push_item(dift_pkg::ACT_QUERY, 64'sd0, 64'sd0, 64'sd0);
    wait_idle();

    $display("Covered %0d items and %0d results over %0d register settings;", accepted,
             results, phases + 1);
    $display("the run ended with a kill of cause %0d.", cause);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

`default_nettype wire

### filelist.f
hw/rtl/dift_pkg.sv
hw/rtl/decoder_inflight_frame_tracker_top.sv
test/testbench.sv
